[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the spline pulse coefficient block.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition must hold at every clock edge out of reset
`define SBC_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: condition");

// Antecedent implies consequent in the same cycle
`define SBC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Antecedent implies consequent in the following cycle
`define SBC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define SBC_ASSERT_ALWAYS(lbl, expr)
`define SBC_ASSERT_IMP(lbl, ante, cons)
`define SBC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[rtl/sbc_pkg.sv]
// Package for the spline pulse Bezier coefficient block: widths, codes,
// command record between front and back, and the buffer fill function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sbc_pkg;

    // Field widths
    localparam int CONT_W     = 5;
    localparam int DEG_W      = 4;
    localparam int PIX_W      = 4;
    localparam int CELL_W     = 8;
    localparam int IDX_W      = 4;
    localparam int FIX_W      = 33;
    localparam int CALC_W     = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam int MAX_DEGREE = 15;
    localparam int BUF_DEPTH  = 2 ** IDX_W;

    // Command queue geometry
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // One in fixed point with 32 fraction bits
    localparam logic [FIX_W-1:0] FIX_ONE = {1'b1, {(FIX_W-1){1'b0}}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CONTINUITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE     = 1'b1;

    // How the coefficient buffer is seeded for one request
    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_UNIT,
        MODE_UP,
        MODE_DOWN
    } sbc_mode_t;

    // Classified request handed from front to back
    typedef struct packed {
        logic             err;
        sbc_mode_t        mode;
        logic [DEG_W-1:0] degree;
        logic [IDX_W-1:0] base;
        logic [IDX_W-1:0] len;
        logic [IDX_W-1:0] passes;
    } sbc_cmd_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        B_IDLE,
        B_FILL,
        B_ISSUE,
        B_PASS,
        B_EMIT
    } sbc_state_t;

    // Initial buffer entry j: zero, unit spike at the base, or halving chain from the base
    function automatic logic [FIX_W-1:0] fill_value(sbc_cmd_t cmd, logic [IDX_W-1:0] j);
        logic [FIX_W-1:0] v;
        v = '0;
        case (cmd.mode)
            MODE_UNIT: if (j == cmd.base) v = FIX_ONE;
            MODE_UP:   if (j >= cmd.base) v = FIX_ONE >> (j - cmd.base);
            MODE_DOWN: if (j <= cmd.base) v = FIX_ONE >> (cmd.base - j);
            default:   v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/sbc_front.sv]
// Front end: configuration registers, request acceptance and classification.
// Depends on sbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbc_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [sbc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [sbc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             start,
    input  wire logic                             fifo_full,
    input  wire logic [sbc_pkg::PIX_W-1:0]        pulse_index,
    input  wire logic signed [sbc_pkg::CELL_W-1:0] cell_position,
    output logic                                  push,
    output sbc_pkg::sbc_cmd_t                     cmd
);

    logic signed [sbc_pkg::CONT_W-1:0] continuity_reg;
    logic [sbc_pkg::DEG_W-1:0]         degree_reg;

    logic signed [sbc_pkg::CALC_W-1:0] c_x;
    logic signed [sbc_pkg::CALC_W-1:0] g_x;
    logic signed [sbc_pkg::CALC_W-1:0] p_x;
    logic signed [sbc_pkg::CALC_W-1:0] xip_x;
    logic signed [sbc_pkg::CALC_W-1:0] span_x;
    logic                              bad;
    logic                              single;
    logic                              at_zero;
    logic                              at_one;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            continuity_reg <= '0;
            degree_reg     <= sbc_pkg::DEG_W'(1);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                sbc_pkg::CFG_CONTINUITY: continuity_reg <= cfg_data;
                sbc_pkg::CFG_DEGREE:     degree_reg <= cfg_data[sbc_pkg::DEG_W-1:0];
                default:                 ;
            endcase
        end
    end

    // Widen settings and index to a common signed width
    always_comb
    begin
        c_x    = sbc_pkg::CALC_W'(continuity_reg);
        g_x    = $signed({{(sbc_pkg::CALC_W-sbc_pkg::DEG_W){1'b0}}, degree_reg});
        p_x    = $signed({{(sbc_pkg::CALC_W-sbc_pkg::PIX_W){1'b0}}, pulse_index});
        xip_x  = g_x - c_x + p_x;
        span_x = c_x - p_x;
    end

    // Classify: error, one-cell pulse, or two-cell pulse on cell 0 or 1
    always_comb
    begin
        bad     = (c_x < -7'sd1)
               || (g_x < ((c_x <<< 1) + 7'sd1))
               || (g_x > $signed(sbc_pkg::CALC_W'(sbc_pkg::MAX_DEGREE)))
               || (p_x > (g_x - c_x - 7'sd1));
        single  = p_x > c_x;
        at_zero = cell_position == 8'sd0;
        at_one  = cell_position == 8'sd1;
    end

    // Build the command record
    always_comb
    begin
        cmd.err    = bad;
        cmd.degree = degree_reg;
        cmd.mode   = sbc_pkg::MODE_ZERO;
        cmd.base   = pulse_index;
        cmd.len    = '0;
        cmd.passes = '0;
        if (single)
        begin
            if (at_zero)
                cmd.mode = sbc_pkg::MODE_UNIT;
        end
        else if (at_zero)
        begin
            cmd.mode   = sbc_pkg::MODE_UP;
            cmd.base   = xip_x[sbc_pkg::IDX_W-1:0];
            cmd.len    = span_x[sbc_pkg::IDX_W-1:0];
            cmd.passes = pulse_index;
        end
        else if (at_one)
        begin
            cmd.mode   = sbc_pkg::MODE_DOWN;
            cmd.base   = pulse_index;
            cmd.len    = pulse_index;
            cmd.passes = span_x[sbc_pkg::IDX_W-1:0];
        end
    end

    assign push = start && !fifo_full;

endmodule

`default_nettype wire

[rtl/sbc_cmd_fifo.sv]
// Two-entry command queue between the front end and the back-end sequencer.
// Depends on sbc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sbc_cmd_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  sbc_pkg::sbc_cmd_t      push_cmd,
    input  wire logic              pop,
    output sbc_pkg::sbc_cmd_t      head_cmd,
    output logic                   empty,
    output logic                   full
);

    sbc_pkg::sbc_cmd_t                entries_reg [sbc_pkg::FIFO_DEPTH];
    logic [sbc_pkg::FIFO_AW-1:0]      wr_ptr_reg;
    logic [sbc_pkg::FIFO_AW-1:0]      rd_ptr_reg;
    logic [sbc_pkg::FIFO_CW-1:0]      count_reg;
    logic [sbc_pkg::FIFO_AW-1:0]      wr_ptr_next;
    logic [sbc_pkg::FIFO_AW-1:0]      rd_ptr_next;
    logic [sbc_pkg::FIFO_CW-1:0]      count_next;

    assign empty    = count_reg == '0;
    assign full     = count_reg == sbc_pkg::FIFO_CW'(sbc_pkg::FIFO_DEPTH);
    assign head_cmd = entries_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == sbc_pkg::FIFO_AW'(sbc_pkg::FIFO_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == sbc_pkg::FIFO_AW'(sbc_pkg::FIFO_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed commands
    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_cmd;
    end

    `SBC_ASSERT_IMP(a_no_overflow, push, !full)
    `SBC_ASSERT_IMP(a_no_underflow, pop, !empty)
    `SBC_ASSERT_NEXT(a_count_track, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

`default_nettype wire

[rtl/sbc_back.sv]
// Back end: coefficient buffer memory, seeding sweep, averaging passes and
// serial result emission. Depends on sbc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sbc_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          fifo_empty,
    input  sbc_pkg::sbc_cmd_t                  head_cmd,
    output logic                               pop,
    output logic                               result_valid,
    output logic [sbc_pkg::IDX_W-1:0]          coef_index,
    output logic [sbc_pkg::FIX_W-1:0]          coef_value,
    output logic                               last_coef,
    output logic                               bad_request
);

    sbc_pkg::sbc_state_t               state_reg;
    sbc_pkg::sbc_state_t               state_next;
    sbc_pkg::sbc_cmd_t                 cmd_reg;
    sbc_pkg::sbc_cmd_t                 cmd_next;
    logic [sbc_pkg::IDX_W-1:0]         j_reg;
    logic [sbc_pkg::IDX_W-1:0]         j_next;
    logic [sbc_pkg::IDX_W-1:0]         k_reg;
    logic [sbc_pkg::IDX_W-1:0]         k_next;
    logic [sbc_pkg::IDX_W-1:0]         p_reg;
    logic [sbc_pkg::IDX_W-1:0]         p_next;
    logic [sbc_pkg::FIX_W-1:0]         prev_reg;
    logic [sbc_pkg::FIX_W-1:0]         prev_next;

    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [sbc_pkg::IDX_W-1:0]         out_index_reg;
    logic [sbc_pkg::IDX_W-1:0]         out_index_next;
    logic                              out_last_reg;
    logic                              out_last_next;
    logic                              out_bad_reg;
    logic                              out_bad_next;

    logic [sbc_pkg::FIX_W-1:0]         buf_mem [sbc_pkg::BUF_DEPTH];
    logic [sbc_pkg::FIX_W-1:0]         rd_data_reg;
    logic                              wr_en;
    logic [sbc_pkg::IDX_W-1:0]         wr_addr;
    logic [sbc_pkg::FIX_W-1:0]         wr_data;
    logic                              rd_en;
    logic [sbc_pkg::IDX_W-1:0]         rd_addr;

    logic                              up_dir;
    logic [sbc_pkg::IDX_W-1:0]         cur_addr;
    logic [sbc_pkg::IDX_W-1:0]         nxt_addr;
    logic [sbc_pkg::IDX_W:0]           pair_sum;
    logic [sbc_pkg::FIX_W-1:0]         avg_val;
    logic [sbc_pkg::FIX_W:0]           sum_wide;
    logic                              pass_end;
    logic                              fill_end;
    logic                              need_pass;

    // Address walk: upward from the base on cell 0, downward on cell 1
    always_comb
    begin
        up_dir    = cmd_reg.mode == sbc_pkg::MODE_UP;
        cur_addr  = up_dir ? cmd_reg.base + k_reg : cmd_reg.base - k_reg;
        pair_sum  = {1'b0, k_reg} + 1'b1;
        nxt_addr  = up_dir ? cmd_reg.base + pair_sum[sbc_pkg::IDX_W-1:0]
                           : cmd_reg.base - pair_sum[sbc_pkg::IDX_W-1:0];
        sum_wide  = {1'b0, rd_data_reg} + {1'b0, prev_reg};
        avg_val   = (k_reg == '0) ? (rd_data_reg >> 1) : sum_wide[sbc_pkg::FIX_W:1];
        pass_end  = k_reg == cmd_reg.len;
        fill_end  = j_reg == cmd_reg.degree;
        need_pass = ((cmd_reg.mode == sbc_pkg::MODE_UP) || (cmd_reg.mode == sbc_pkg::MODE_DOWN))
                 && (cmd_reg.passes != '0);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sbc_pkg::B_IDLE:
            begin
                if (!fifo_empty && !head_cmd.err)
                    state_next = sbc_pkg::B_FILL;
            end
            sbc_pkg::B_FILL:
            begin
                if (fill_end)
                    state_next = need_pass ? sbc_pkg::B_ISSUE : sbc_pkg::B_EMIT;
            end
            sbc_pkg::B_ISSUE:
                state_next = sbc_pkg::B_PASS;
            sbc_pkg::B_PASS:
            begin
                if (pass_end)
                    state_next = (p_reg == sbc_pkg::IDX_W'(1)) ? sbc_pkg::B_EMIT
                                                               : sbc_pkg::B_ISSUE;
            end
            sbc_pkg::B_EMIT:
            begin
                if (fill_end)
                    state_next = sbc_pkg::B_IDLE;
            end
            default:
                state_next = sbc_pkg::B_IDLE;
        endcase
    end

    // Datapath and result controls
    always_comb
    begin
        pop            = 1'b0;
        cmd_next       = cmd_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        p_next         = p_reg;
        prev_next      = prev_reg;
        wr_en          = 1'b0;
        wr_addr        = j_reg;
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = j_reg;
        out_valid_next = 1'b0;
        out_index_next = '0;
        out_last_next  = 1'b0;
        out_bad_next   = 1'b0;
        case (state_reg)
            sbc_pkg::B_IDLE:
            begin
                // Take the next command; an error answers at once
                if (!fifo_empty)
                begin
                    pop      = 1'b1;
                    cmd_next = head_cmd;
                    j_next   = '0;
                    if (head_cmd.err)
                    begin
                        out_valid_next = 1'b1;
                        out_last_next  = 1'b1;
                        out_bad_next   = 1'b1;
                    end
                end
            end
            sbc_pkg::B_FILL:
            begin
                // Seed entries 0..degree
                wr_en   = 1'b1;
                wr_addr = j_reg;
                wr_data = sbc_pkg::fill_value(cmd_reg, j_reg);
                j_next  = fill_end ? '0 : j_reg + 1'b1;
                p_next  = cmd_reg.passes;
            end
            sbc_pkg::B_ISSUE:
            begin
                // Fetch the head entry of the pass
                rd_en   = 1'b1;
                rd_addr = cmd_reg.base;
                k_next  = '0;
            end
            sbc_pkg::B_PASS:
            begin
                // Halve the head, then average each entry with its new neighbor
                wr_en     = 1'b1;
                wr_addr   = cur_addr;
                wr_data   = avg_val;
                prev_next = avg_val;
                if (pass_end)
                begin
                    p_next = p_reg - 1'b1;
                    j_next = '0;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = nxt_addr;
                    k_next  = k_reg + 1'b1;
                end
            end
            sbc_pkg::B_EMIT:
            begin
                // Read out one coefficient per cycle
                rd_en          = 1'b1;
                rd_addr        = j_reg;
                out_valid_next = 1'b1;
                out_index_next = j_reg;
                out_last_next  = fill_end;
                j_next         = fill_end ? '0 : j_reg + 1'b1;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sbc_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        j_reg         <= j_next;
        k_reg         <= k_next;
        p_reg         <= p_next;
        prev_reg      <= prev_next;
        out_index_reg <= out_index_next;
        out_last_reg  <= out_last_next;
        out_bad_reg   <= out_bad_next;
    end

    // Coefficient buffer: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            buf_mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= buf_mem[rd_addr];
    end

    assign result_valid = out_valid_reg;
    assign coef_index   = out_index_reg;
    assign coef_value   = out_bad_reg ? '0 : rd_data_reg;
    assign last_coef    = out_last_reg;
    assign bad_request  = out_bad_reg;

    `SBC_ASSERT_IMP(a_bad_is_last, out_valid_reg && out_bad_reg, out_last_reg)
    `SBC_ASSERT_IMP(a_pass_count, state_reg == sbc_pkg::B_PASS, p_reg != '0)
    `SBC_ASSERT_NEXT(a_emit_order, out_valid_reg && !out_last_reg,
        out_valid_reg && (out_index_reg == $past(out_index_reg) + 1'b1))
    `SBC_ASSERT_IMP(a_pop_idle, pop, state_reg == sbc_pkg::B_IDLE)

endmodule

`default_nettype wire

[rtl/spline_pulse_bezier_coeffs.sv]
// Top level of the spline pulse Bezier coefficient block.
// Depends on sbc_pkg, sbc_front, sbc_cmd_fifo and sbc_back.
//
//   channel   handshake                 payload
//   -------   -----------------------   ------------------------------------
//   config    cfg_valid / cfg_ready     cfg_index, cfg_data
//   request   start / busy              pulse_index, cell_position
//   result    result_valid (strobe)     coef_index, coef_value, last_coef,
//                                       bad_request
//
// An invalid request answers with a single result in the cycle after it leaves
// the queue. A valid one seeds buffer entries 0..degree, then runs its averaging
// passes, each a fetch of the head entry and a sweep over len+1 entries from the
// base, then reads out entries 0..degree; the coefficient buffer has one write and
// one read port and handles one entry per cycle in every sweep.
// Two commands may wait in the queue while the back end works; busy is high
// while the queue is full. Reset is asynchronous; the buffer is not cleared.
// Results appear for one cycle each, in order, and cannot be held off.
`timescale 1ns / 1ps
`default_nettype none

module spline_pulse_bezier_coeffs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [sbc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sbc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [sbc_pkg::PIX_W-1:0]         pulse_index,
    input  wire logic signed [sbc_pkg::CELL_W-1:0] cell_position,
    output logic                                   result_valid,
    output logic [sbc_pkg::IDX_W-1:0]              coef_index,
    output logic [sbc_pkg::FIX_W-1:0]              coef_value,
    output logic                                   last_coef,
    output logic                                   bad_request
);

    logic              push;
    logic              pop;
    logic              fifo_full;
    logic              fifo_empty;
    sbc_pkg::sbc_cmd_t push_cmd;
    sbc_pkg::sbc_cmd_t head_cmd;

    assign busy = fifo_full;

    // Accept and classify requests
    sbc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .start         (start),
        .fifo_full     (fifo_full),
        .pulse_index   (pulse_index),
        .cell_position (cell_position),
        .push          (push),
        .cmd           (push_cmd)
    );

    // Hold classified commands
    sbc_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (fifo_empty),
        .full     (fifo_full)
    );

    // Compute and emit coefficients
    sbc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .fifo_empty   (fifo_empty),
        .head_cmd     (head_cmd),
        .pop          (pop),
        .result_valid (result_valid),
        .coef_index   (coef_index),
        .coef_value   (coef_value),
        .last_coef    (last_coef),
        .bad_request  (bad_request)
    );

endmodule

`default_nettype wire
